// ----- sv/rdq_pkg.sv -----
// Shared request codes, status codes and the cell command type for the ring buffer deque.
package rdq_pkg;

  // Default sizing of the deque.
  localparam int unsigned DefSize      = 15;
  localparam int unsigned DefDataWidth = 32;

  // Field widths on the stream ports.
  localparam int unsigned ValueW  = 32;
  localparam int unsigned ReqW    = 2;
  localparam int unsigned StatusW = 2;

  typedef enum logic [ReqW-1:0] {
    REQ_PUSH_FRONT  = 2'd0,
    REQ_POP_FRONT   = 2'd1,
    REQ_INJECT_REAR = 2'd2,
    REQ_EJECT_REAR  = 2'd3
  } req_e;

  typedef enum logic [StatusW-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RSVD  = 2'd3
  } status_e;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    logic en;
    req_e op;
  } cell_cmd_t;

endpackage

// ----- sv/ring_buffer_deque_core.sv -----
// Top level of the ring buffer deque: a row of shifting cells with a registered result stage.
// The result of a request is registered and appears in the cycle after the request item is accepted.
// Throughput: one request per cycle while the output is not stalled; the row of cells updates every cell together.
// The output register frees itself when its result is taken, so input and output overlap.
// Reset (rst_ni low, asynchronous) empties the deque and drops any pending result.
// Stored words are not cleared; only the per-cell occupied flags are reset.
module ring_buffer_deque_core
  import rdq_pkg::*;
#(
  parameter int unsigned SIZE       = DefSize,
  parameter int unsigned DATA_WIDTH = DefDataWidth
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [ValueW-1:0]               s_axis_tdata,  // [31:0] value
  input  logic [ReqW-1:0]                 s_axis_tuser,  // [1:0] req_type
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [ValueW-1:0]               m_axis_tdata,  // [31:0] data_out
  output logic [StatusW+1:0]              m_axis_tuser   // [1:0] status, [2] now_full,
                                                         // [3] now_empty
);

  logic                  accept;
  req_e                  req;
  logic [DATA_WIDTH+ValueW-1:0] value_wide;
  logic [DATA_WIDTH-1:0] value_st;

  logic [DATA_WIDTH-1:0] cell_data  [SIZE+1];
  logic                  cell_valid [SIZE+1];
  logic                  cell_vnext [SIZE];
  logic                  cell_tail  [SIZE];
  logic [DATA_WIDTH-1:0] tail_word  [SIZE+1];

  logic                  is_full, is_empty, is_insert, rejected;
  cell_cmd_t             cmd;
  status_e               status;
  logic [DATA_WIDTH-1:0] removed;
  logic [DATA_WIDTH+ValueW-1:0] removed_wide;

  logic                  out_valid_q;
  logic [ValueW-1:0]     out_data_q;
  status_e               out_status_q;
  logic                  out_full_q, out_empty_q;

  // Input decode; the word is zero-extended or truncated to the stored width.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign req           = req_e'(s_axis_tuser);
  assign value_wide    = {{DATA_WIDTH{1'b0}}, s_axis_tdata};
  assign value_st      = value_wide[DATA_WIDTH-1:0];

  // Occupancy flags come straight from the boundary cells.
  assign is_full   = cell_valid[SIZE-1];
  assign is_empty  = !cell_valid[0];
  assign is_insert = (req == REQ_PUSH_FRONT) || (req == REQ_INJECT_REAR);
  assign rejected  = is_insert ? is_full : is_empty;
  assign cmd.en    = accept && !rejected;
  assign cmd.op    = req;

  // Right boundary of the row reads as an empty cell.
  assign cell_data[SIZE]  = '0;
  assign cell_valid[SIZE] = 1'b0;
  assign tail_word[0]     = '0;

  // Row of cells; the left neighbor of the first cell is the incoming word.
  for (genvar i = 0; i < SIZE; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_data;
    logic                  left_valid;

    if (i == 0) begin : g_head
      assign left_data  = value_st;
      assign left_valid = 1'b1;
    end else begin : g_body
      assign left_data  = cell_data[i-1];
      assign left_valid = cell_valid[i-1];
    end

    rdq_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .value_i      (value_st),
      .left_data_i  (left_data),
      .left_valid_i (left_valid),
      .right_data_i (cell_data[i+1]),
      .right_valid_i(cell_valid[i+1]),
      .data_o       (cell_data[i]),
      .valid_o      (cell_valid[i]),
      .valid_next_o (cell_vnext[i]),
      .tail_o       (cell_tail[i])
    );

    // The rear word is gathered along the row from the single tail cell.
    assign tail_word[i+1] = tail_word[i] | (cell_tail[i] ? cell_data[i] : '0);
  end

  // Removed word and status of the current request.
  always_comb begin
    removed = '0;
    status  = ST_DONE;
    if (rejected) begin
      status = is_insert ? ST_FULL : ST_EMPTY;
    end else if (req == REQ_POP_FRONT) begin
      removed = cell_data[0];
    end else if (req == REQ_EJECT_REAR) begin
      removed = tail_word[SIZE];
    end
  end

  assign removed_wide = {{ValueW{1'b0}}, removed};

  // Result register: filled on accept, emptied when the item is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q   <= removed_wide[ValueW-1:0];
      out_status_q <= status;
      out_full_q   <= cell_vnext[SIZE-1];
      out_empty_q  <= !cell_vnext[0];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = {out_empty_q, out_full_q, out_status_q};

endmodule

// ----- sv/rdq_cell.sv -----
// One storage cell of the deque row: holds a word and an occupied flag.
module rdq_cell
  import rdq_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DefDataWidth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cell_cmd_t             cmd_i,
  input  logic [DATA_WIDTH-1:0] value_i,
  input  logic [DATA_WIDTH-1:0] left_data_i,
  input  logic                  left_valid_i,
  input  logic [DATA_WIDTH-1:0] right_data_i,
  input  logic                  right_valid_i,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic                  valid_o,
  output logic                  valid_next_o,
  output logic                  tail_o
);

  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic                  valid_q, valid_d;

  // Next contents: a front push shifts rearward, a front pop shifts frontward,
  // rear operations touch only the boundary cell.
  always_comb begin
    data_d  = data_q;
    valid_d = valid_q;
    if (cmd_i.en) begin
      unique case (cmd_i.op)
        REQ_PUSH_FRONT: begin
          data_d  = left_data_i;
          valid_d = left_valid_i;
        end
        REQ_POP_FRONT: begin
          data_d  = right_data_i;
          valid_d = right_valid_i;
        end
        REQ_INJECT_REAR: begin
          if (!valid_q && left_valid_i) begin
            data_d  = value_i;
            valid_d = 1'b1;
          end
        end
        REQ_EJECT_REAR: begin
          if (valid_q && !right_valid_i) begin
            valid_d = 1'b0;
          end
        end
        default: begin
          data_d  = data_q;
          valid_d = valid_q;
        end
      endcase
    end
  end

  // The occupied flag is control state; the word itself needs no reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o       = data_q;
  assign valid_o      = valid_q;
  assign valid_next_o = valid_d;
  assign tail_o       = valid_q && !right_valid_i;

endmodule

// ----- bench/ring_buffer_deque_checker.sv -----
// Scoreboard for the ring buffer deque: predicts each result and compares it on the output stream.
`timescale 1ns / 100ps

module ring_buffer_deque_checker
  import rdq_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_tvalid_i,
  input  logic               s_tready_i,
  input  logic [ValueW-1:0]  s_tdata_i,     // [31:0] value
  input  logic [ReqW-1:0]    s_tuser_i,     // [1:0] req_type
  input  logic               m_tvalid_i,
  input  logic               m_tready_i,
  input  logic [ValueW-1:0]  m_tdata_i,     // [31:0] data_out
  input  logic [StatusW+1:0] m_tuser_i,     // [1:0] status, [2] now_full, [3] now_empty
  output int unsigned        fail_count_o,
  output int unsigned        pending_o,
  output int unsigned        results_seen_o,
  output int unsigned        full_rejects_o,
  output int unsigned        empty_rejects_o,
  output int unsigned        full_reached_o
);

  localparam int unsigned RingLen = DefSize + 1;

  typedef struct {
    logic [ValueW-1:0] data;
    status_e           status;
    logic              now_full;
    logic              now_empty;
  } deque_result_t;

  // Shadow copy of the ring and its two pointers.
  logic [DefDataWidth-1:0] ring_q [RingLen];
  int unsigned             front_q;
  int unsigned             rear_q;
  deque_result_t           expected_results [$];

  function automatic int unsigned ring_prev(int unsigned idx);
    return (idx == 0) ? RingLen - 1 : idx - 1;
  endfunction

  function automatic int unsigned ring_next(int unsigned idx);
    return (idx + 1 >= RingLen) ? 0 : idx + 1;
  endfunction

  // Applies one request to the shadow deque and returns the result it must produce.
  function automatic deque_result_t apply_request(req_e op, logic [ValueW-1:0] word);
    deque_result_t res;
    logic          is_full;
    logic          is_empty;
    is_full    = (ring_prev(front_q) == rear_q);
    is_empty   = (front_q == rear_q);
    res.data   = '0;
    res.status = ST_DONE;
    case (op)
      REQ_PUSH_FRONT: begin
        if (is_full) begin
          res.status = ST_FULL;
        end else begin
          front_q          = ring_prev(front_q);
          ring_q[front_q]  = word[DefDataWidth-1:0];
        end
      end
      REQ_POP_FRONT: begin
        if (is_empty) begin
          res.status = ST_EMPTY;
        end else begin
          res.data = ring_q[front_q];
          front_q  = ring_next(front_q);
        end
      end
      REQ_INJECT_REAR: begin
        if (is_full) begin
          res.status = ST_FULL;
        end else begin
          ring_q[rear_q] = word[DefDataWidth-1:0];
          rear_q         = ring_next(rear_q);
        end
      end
      default: begin
        if (is_empty) begin
          res.status = ST_EMPTY;
        end else begin
          rear_q   = ring_prev(rear_q);
          res.data = ring_q[rear_q];
        end
      end
    endcase
    res.now_full  = (ring_prev(front_q) == rear_q);
    res.now_empty = (front_q == rear_q);
    return res;
  endfunction

  assign pending_o = expected_results.size();

  // Compare each taken result with the oldest expectation, then predict for a new request.
  always @(posedge clk_i or negedge rst_ni) begin
    deque_result_t exp_res;
    deque_result_t new_res;
    if (!rst_ni) begin
      front_q          = 0;
      rear_q           = 0;
      expected_results.delete();
      fail_count_o    <= 0;
      results_seen_o  <= 0;
      full_rejects_o  <= 0;
      empty_rejects_o <= 0;
      full_reached_o  <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        results_seen_o <= results_seen_o + 1;
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing expected: data %h user %h",
                   $time, m_tdata_i, m_tuser_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_res = expected_results.pop_front();
          if (m_tdata_i !== exp_res.data || m_tuser_i[1:0] !== exp_res.status ||
              m_tuser_i[2] !== exp_res.now_full || m_tuser_i[3] !== exp_res.now_empty) begin
            $display("%0t: mismatch expected data %h status %0d full %b empty %b", $time,
                     exp_res.data, exp_res.status, exp_res.now_full, exp_res.now_empty);
            $display("%0t:          actual   data %h status %0d full %b empty %b", $time,
                     m_tdata_i, m_tuser_i[1:0], m_tuser_i[2], m_tuser_i[3]);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        new_res = apply_request(req_e'(s_tuser_i), s_tdata_i);
        expected_results.push_back(new_res);
        if (new_res.status == ST_FULL) full_rejects_o <= full_rejects_o + 1;
        if (new_res.status == ST_EMPTY) empty_rejects_o <= empty_rejects_o + 1;
        if (new_res.now_full && new_res.status == ST_DONE) full_reached_o <= full_reached_o + 1;
      end
    end
  end

endmodule

// ----- bench/tb_ring_buffer_deque_core.sv -----
// Testbench top for the ring buffer deque: request stimulus, output stalls and the verdict.
`timescale 1ns / 100ps

module tb_ring_buffer_deque_core;
  import rdq_pkg::*;

  localparam int unsigned RandomItems = 1525;
  localparam int unsigned IdleLimit   = 5000;
  localparam int unsigned DrainCycles = 4;

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [ValueW-1:0]  s_axis_tdata;
  logic [ReqW-1:0]    s_axis_tuser;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [ValueW-1:0]  m_axis_tdata;
  logic [StatusW+1:0] m_axis_tuser;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned results_seen;
  int unsigned full_rejects;
  int unsigned empty_rejects;
  int unsigned full_reached;
  int unsigned idle_cycles;

  ring_buffer_deque_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  ring_buffer_deque_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_tvalid_i     (s_axis_tvalid),
    .s_tready_i     (s_axis_tready),
    .s_tdata_i      (s_axis_tdata),
    .s_tuser_i      (s_axis_tuser),
    .m_tvalid_i     (m_axis_tvalid),
    .m_tready_i     (m_axis_tready),
    .m_tdata_i      (m_axis_tdata),
    .m_tuser_i      (m_axis_tuser),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .results_seen_o (results_seen),
    .full_rejects_o (full_rejects),
    .empty_rejects_o(empty_rejects),
    .full_reached_o (full_reached)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Output stall pattern: switches between always ready, random and periodic stalls.
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;
  int unsigned stall_tick = 0;

  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(3);
      stall_left = $urandom_range(200, 40);
    end
    stall_left = stall_left - 1;
    stall_tick = stall_tick + 1;
    case (stall_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= ($urandom_range(99) < 75);
      2:       m_axis_tready <= ($urandom_range(99) < 30);
      default: m_axis_tready <= (stall_tick % 4 == 0);
    endcase
  end

  // Watchdog: ends the run when neither side moves an item for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: no item moved for %0d cycles", $time, IdleLimit);
        $display("FAIL");
        $finish;
      end
    end
  end

  // Present one request and hold it until the deque accepts it.
  task automatic send_request(req_e op, logic [ValueW-1:0] word);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  function automatic logic [ValueW-1:0] pick_word();
    case ($urandom_range(15))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  int unsigned burst_left;

  // Sender idling: after each burst, a random gap, sometimes none.
  task automatic burst_pause();
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(9) == 0) ? $urandom_range(80, 30) : $urandom_range(12, 1);
      gap = ($urandom_range(9) < 3) ? 0 : $urandom_range(6, 1);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  initial begin
    int unsigned insert_pct;
    int unsigned segment_left;
    req_e        op;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= REQ_PUSH_FRONT;
    burst_left    = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: removals from the empty deque, extreme words, fill to full, inserts while full.
    send_request(REQ_POP_FRONT, 32'hffff_ffff);
    send_request(REQ_EJECT_REAR, 32'h0000_0000);
    send_request(REQ_PUSH_FRONT, 32'h7fff_ffff);
    send_request(REQ_INJECT_REAR, 32'h8000_0000);
    send_request(REQ_POP_FRONT, 32'h0);
    send_request(REQ_EJECT_REAR, 32'h0);
    for (int i = 0; i < DefSize; i++) begin
      burst_pause();
      send_request((i % 2) ? REQ_PUSH_FRONT : REQ_INJECT_REAR,
                   (i % 4 == 0) ? 32'h8000_0000 : (i % 4 == 1) ? 32'h7fff_ffff :
                   (i % 4 == 2) ? 32'hffff_ffff : 32'h0000_0001);
    end
    send_request(REQ_PUSH_FRONT, 32'h1234_5678);
    send_request(REQ_INJECT_REAR, 32'hdead_beef);
    send_request(REQ_EJECT_REAR, 32'h0);
    send_request(REQ_POP_FRONT, 32'h0);

    // Random: segments that lean toward filling, balancing or draining the deque.
    segment_left = 0;
    insert_pct   = 50;
    for (int n = 0; n < RandomItems; n++) begin
      if (segment_left == 0) begin
        segment_left = $urandom_range(60, 20);
        case ($urandom_range(2))
          0:       insert_pct = 85;
          1:       insert_pct = 50;
          default: insert_pct = 15;
        endcase
      end
      segment_left--;
      if ($urandom_range(99) < insert_pct) begin
        op = $urandom_range(1) ? REQ_PUSH_FRONT : REQ_INJECT_REAR;
      end else begin
        op = $urandom_range(1) ? REQ_POP_FRONT : REQ_EJECT_REAR;
      end
      burst_pause();
      send_request(op, pick_word());
    end
    s_axis_tvalid <= 1'b0;

    // Wait for every result, then keep watching the output for anything unexpected.
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Checked %0d results; inserts refused as full: %0d, removals refused as empty: %0d",
             results_seen, full_rejects, empty_rejects);
    $display("The deque was filled to capacity %0d times under random output stalls",
             full_reached);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
